@@ sv/modular_inverse_ext_euclid_assert.svh @@
// assertion macros for the modular inverse block
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`ifndef SYNTHESIS
`define MIE_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define MIE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MIE_ASSERT_IMPL(label, clk, rst, prop)
`define MIE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ sv/mie_pkg.sv @@
package mie_pkg;
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_COPRIME = 2'd1;
  localparam logic [1:0] ST_OVER_LIMIT  = 2'd2;
  localparam logic [31:0] LIMIT_RESET   = 32'd1000000000;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;
endpackage

@@ sv/modular_inverse_ext_euclid.sv @@
// channel   dir  fields (low bit first)
// s_axis    in   tdata: modulus_k[31:0], multiplier_c[63:32]
// m_axis    out  tdata: answer_y[31:0]; tuser: status[1:0]
// cfg       in   result_limit, written when cfg_we is high
// a word with a zero operand goes straight to the output with not coprime status;
// otherwise the euclid steps run, and a coprime word is then reduced and limited;
// each euclid step uses the shared bit-serial divider, then the shared multiplier
// for the bezout update. rst is synchronous, clears control and reloads the limit.
// the output word is held in a register; a stalled output holds the block busy
// only until the word is taken, the input is not ready while an item runs.
`include "modular_inverse_ext_euclid_assert.svh"
module modular_inverse_ext_euclid #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // modulus_k, multiplier_c
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // answer_y
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  localparam int W = DATA_WIDTH;
  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_DIVW = 4'd2, S_MUL = 4'd3,
    S_MULW = 4'd4, S_FIN = 4'd5, S_RED = 4'd6, S_REDW = 4'd7, S_NEED = 4'd8,
    S_NEEDW = 4'd9, S_OUT = 4'd10;

  logic [3:0]   state;
  logic [31:0]  result_limit;
  logic [W-1:0] k, c, a, b, prev_mag, cur_mag, y0;
  logic         prev_neg, cur_neg;
  logic [31:0]  out_y;
  logic [1:0]   out_st;

  logic         d_start, d_busy, d_done;
  logic [W-1:0] d_n, d_d, d_q, d_r;
  logic         m_start, m_busy, m_done;
  logic [W:0]   m_p;
  logic [W-1:0] q_hold;

  mie_div #(.W(W)) u_div (.clk, .rst, .start(d_start), .dividend(d_n), .divisor(d_d),
    .busy(d_busy), .done(d_done), .quot(d_q), .rem(d_r));
  mie_mul #(.W(W)) u_mul (.clk, .rst, .start(m_start), .op_a(cur_mag), .op_b(q_hold),
    .addend(prev_mag), .busy(m_busy), .done(m_done), .prod(m_p));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = out_y;
  assign m_axis_tuser  = out_st;

  // divider operand select by phase
  always_comb begin
    d_start = 1'b0;
    d_n = a;
    d_d = b;
    case (state)
      S_DIV:  d_start = 1'b1;
      S_RED:  begin d_start = 1'b1; d_n = prev_mag; d_d = k; end
      S_NEED: begin d_start = 1'b1; d_n = k; d_d = c; end
      default: ;
    endcase
  end
  assign m_start = (state == S_MUL);

  // final selection math, one bit wider than the data to absorb carries
  logic [W:0]  need;
  logic [W:0]  need_less_k;
  logic [W-1:0] n_mod;
  logic [W:0]  diff;
  logic [32:0] lim;
  assign need  = {1'b0, d_q} + 1'b1;
  // need is at most k + 1, so one subtraction reduces it modulo k
  assign need_less_k = need - {1'b0, k};
  assign n_mod = (k == W'(1)) ? '0 :
                 (need >= {1'b0, k}) ? need_less_k[W-1:0] : need[W-1:0];
  assign diff  = (y0 >= n_mod) ? {1'b0, y0 - n_mod} : {1'b0, y0} + {1'b0, k - n_mod};
  assign lim   = {1'b0, result_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_limit <= mie_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we) result_limit <= cfg_wdata;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          k <= W'(s_axis_tdata[31:0]);
          c <= W'(s_axis_tdata[63:32]);
          a <= W'(s_axis_tdata[31:0]);
          b <= W'(s_axis_tdata[63:32]);
          prev_mag <= '0; cur_mag <= W'(1);
          prev_neg <= 1'b0; cur_neg <= 1'b0;
          out_y <= '0; out_st <= mie_pkg::ST_NOT_COPRIME;
          if (W'(s_axis_tdata[31:0]) == '0 || W'(s_axis_tdata[63:32]) == '0)
            state <= S_OUT;
          else
            state <= S_DIV;
        end
        S_DIV:  state <= S_DIVW;
        S_DIVW: if (d_done) begin
          q_hold <= d_q;
          a <= b;
          b <= d_r;
          state <= S_MUL;
        end
        S_MUL:  state <= S_MULW;
        S_MULW: if (m_done) begin
          // magnitudes of bezout coefficients never exceed k
          prev_mag <= cur_mag; prev_neg <= cur_neg;
          cur_mag <= m_p[W-1:0]; cur_neg <= !cur_neg;
          state <= (b == '0) ? S_FIN : S_DIV;
        end
        S_FIN:  state <= (a == W'(1)) ? S_RED : S_OUT;
        S_RED:  state <= S_REDW;
        S_REDW: if (d_done) begin
          y0 <= (prev_neg && d_r != '0) ? k - d_r : d_r;
          state <= S_NEED;
        end
        S_NEED:  state <= S_NEEDW;
        S_NEEDW: if (d_done) begin
          if (65'(need) > 65'(lim)) begin
            out_st <= mie_pkg::ST_OVER_LIMIT;
          end else if (65'(diff) > 65'(lim) - 65'(need)) begin
            out_st <= mie_pkg::ST_OVER_LIMIT;
          end else begin
            out_st <= mie_pkg::ST_OK;
            out_y <= 32'(need + diff);
          end
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `MIE_ASSERT_IMPL(a_ok_nonzero, clk, rst, (m_axis_tvalid && m_axis_tuser != mie_pkg::ST_OK) |-> (m_axis_tdata == '0))
  `MIE_ASSERT_IMPL(a_one_hot_hs, clk, rst, !(s_axis_tready && m_axis_tvalid))
  `MIE_ASSERT_IMPL(a_units_excl, clk, rst, !(d_busy && m_busy))
  `MIE_ASSERT_IMPL(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
endmodule

@@ sv/mie_div.sv @@
// restoring divider, one quotient bit per cycle
module mie_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;

  assign trial = {rem, quot[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem  <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= {rem[W-2:0], quot[W-1]};
        quot <= {quot[W-2:0], 1'b0};
      end
    end
  end
endmodule

@@ sv/mie_mul.sv @@
// shift-add multiplier with a wider accumulator, one bit per cycle
module mie_mul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  input  logic [W-1:0] addend,
  output logic         busy,
  output logic         done,
  output logic [W:0]   prod
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt;
  logic [W-1:0]  mb;
  logic [2*W:0]  acc;
  logic [2*W:0]  shifted;

  assign shifted = {acc[2*W-1:0], 1'b0};
  assign prod = (acc[2*W:W+1] != '0) ? {(W+1){1'b1}} : acc[W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // msb first: acc = 2*acc + bit*a, addend added unshifted in the final step
  logic [2*W:0] addend_scaled;
  assign addend_scaled = {{(W+1){1'b0}}, addend};

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mb  <= op_b;
    end else if (busy) begin
      mb <= {mb[W-2:0], 1'b0};
      if (cnt == CW'(1))
        acc <= shifted + (mb[W-1] ? {{(W+1){1'b0}}, op_a} : '0) + addend_scaled;
      else
        acc <= shifted + (mb[W-1] ? {{(W+1){1'b0}}, op_a} : '0);
    end
  end
endmodule
